// ===== rtl/can_signal_unpacker_defines.svh =====
// Assertion macros shared by the unpacker's checks.
`ifndef CAN_SIGNAL_UNPACKER_DEFINES_SVH
`define CAN_SIGNAL_UNPACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("unpacker check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("unpacker check failed");

`endif

// ===== rtl/csu_pkg.sv =====
package csu_pkg;

   // Default table sizes.
   localparam int DEF_MSG_SLOTS    = 16;
   localparam int DEF_SIGS_PER_MSG = 8;
   localparam int DEF_SIGNAL_IDS   = 256;

   // No frame ever yields more than this many signals.
   localparam int MAX_EMIT = 8;

   // Request kinds.
   localparam logic [1:0] KIND_MSG   = 2'd0;
   localparam logic [1:0] KIND_SLOT  = 2'd1;
   localparam logic [1:0] KIND_FRAME = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // One stored signal slot.
   typedef struct packed {
      logic [6:0] bit_length;
      logic [5:0] start_bit;
      logic [7:0] signal_id;
   } slot_type;

endpackage

// ===== rtl/can_signal_unpacker.sv =====
// Timing: a load beat completes at its accept edge; a frame searches the message table
// one entry per cycle until the matching entry or the last one, then for each signal
// reads the slot memory (FETCH) and then strobes the result (EMIT).
// Throughput: no new request is accepted until a frame has finished; load beats go
// one per cycle while no frame is in progress.
// Reset: synchronous; clears the sequencer and all message valid flags, no clear pass.
`include "can_signal_unpacker_defines.svh"

module can_signal_unpacker #(
   parameter int MSG_SLOTS    = csu_pkg::DEF_MSG_SLOTS,
   parameter int SIGS_PER_MSG = csu_pkg::DEF_SIGS_PER_MSG,
   parameter int SIGNAL_IDS   = csu_pkg::DEF_SIGNAL_IDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_msg_index,
   input  logic [2:0]  req_slot_index,
   input  logic [10:0] req_can_id,
   input  logic [3:0]  req_sig_count,
   input  logic [7:0]  req_signal_id,
   input  logic [5:0]  req_start_bit,
   input  logic [6:0]  req_bit_length,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_signal_id,
   output logic [7:0]  rsp_out_value,
   output logic        rsp_last
);

   import csu_pkg::*;

   localparam int MSG_W   = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
   localparam int DEPTH   = MSG_SLOTS * SIGS_PER_MSG;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIM_INT = (SIGS_PER_MSG < MAX_EMIT) ? SIGS_PER_MSG : MAX_EMIT;
   localparam logic [3:0] CNT_LIM = 4'(LIM_INT);
   localparam logic [MSG_W-1:0] LAST_MSG = MSG_W'(MSG_SLOTS - 1);

   // Message table: flops, valid flags reset.
   logic [10:0] ident_ff [MSG_SLOTS];
   logic [3:0]  total_ff [MSG_SLOTS];
   logic        valid_ff [MSG_SLOTS];

   // Slot memory, one write and one registered read port.
   slot_type    slot_mem [DEPTH];
   slot_type    rd_ff;

   state_type   state_ff, state_in;
   logic [MSG_W-1:0] m_ff, m_in;
   logic [2:0]  k_ff, k_in;
   logic [3:0]  n_ff, n_in;
   logic [10:0] id_ff, id_in;
   logic [63:0] payload_ff, payload_in;

   logic        accept;
   logic        msg_ok;
   logic        slot_ok;
   logic        hit;
   logic [3:0]  lim;
   logic        is_last;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [MSG_W-1:0]  wr_msg;
   logic [63:0] shifted;
   logic [7:0]  mask8;

   assign accept  = start && !busy;
   assign msg_ok  = 32'(req_msg_index) < MSG_SLOTS;
   assign slot_ok = msg_ok && (32'(req_slot_index) < SIGS_PER_MSG)
                    && (32'(req_signal_id) < SIGNAL_IDS);
   assign wr_msg  = MSG_W'(req_msg_index);
   assign wr_addr = ADDR_W'(wr_msg) * ADDR_W'(SIGS_PER_MSG) + ADDR_W'(req_slot_index);
   assign rd_addr = ADDR_W'(m_ff) * ADDR_W'(SIGS_PER_MSG) + ADDR_W'(k_ff);

   // Shared compare unit: one table entry per cycle against the frame identifier.
   assign hit = valid_ff[m_ff] && (ident_ff[m_ff] == id_ff);
   assign lim = (total_ff[m_ff] > CNT_LIM) ? CNT_LIM : total_ff[m_ff];
   assign is_last = (4'(k_ff) + 4'd1) == n_ff;

   // Shared shift unit: field bits of the current slot, cut to eight.
   assign shifted = payload_ff >> rd_ff.start_bit;
   assign mask8   = (|rd_ff.bit_length[6:3]) ? 8'hFF
                    : 8'((9'd1 << rd_ff.bit_length[2:0]) - 9'd1);

   // Table and slot writes from load beats, and the registered slot read.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MSG_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (accept && (req_kind == KIND_MSG) && msg_ok) begin
         valid_ff[wr_msg] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_kind == KIND_MSG) && msg_ok) begin
         ident_ff[wr_msg] <= req_can_id;
         total_ff[wr_msg] <= req_sig_count;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_kind == KIND_SLOT) && slot_ok) begin
         slot_mem[wr_addr] <= '{bit_length: req_bit_length,
                                start_bit:  req_start_bit,
                                signal_id:  req_signal_id};
      end
      if (state_ff == ST_FETCH) begin
         rd_ff <= slot_mem[rd_addr];
      end
   end

   // Sequencer datapath next values.
   always_comb begin
      m_in       = m_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_FRAME)) begin
               m_in       = '0;
               id_in      = req_can_id;
               payload_in = req_payload;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               n_in = lim;
               k_in = '0;
            end else if (m_ff != LAST_MSG) begin
               m_in = m_ff + MSG_W'(1);
            end
         end
         ST_FETCH: begin
         end
         ST_EMIT: begin
            k_in = k_ff + 3'd1;
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_FRAME)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               state_in = (lim == 4'd0) ? ST_IDLE : ST_FETCH;
            end else if (m_ff == LAST_MSG) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = is_last ? ST_IDLE : ST_FETCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy              = (state_ff != ST_IDLE);
      rsp_valid         = (state_ff == ST_EMIT);
      rsp_out_signal_id = rd_ff.signal_id;
      rsp_out_value     = shifted[7:0] & mask8;
      rsp_last          = is_last;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      id_ff      <= id_in;
      payload_ff <= payload_in;
   end

   // Checks.
   `CSU_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_valid, busy)
   `CSU_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_last, !busy)
   `CSU_ASSERT_NEXT(a_gap_between, clock, reset, rsp_valid && !rsp_last, !rsp_valid && busy)
   `CSU_ASSERT_NEXT(a_load_quick, clock, reset, accept && (req_kind != KIND_FRAME), !busy)

endmodule
